### sv/polyline_ribbon_tessellator_macros.svh
// Assertion macros used by the checker file of the ribbon tessellator.
`ifndef POLYLINE_RIBBON_TESSELLATOR_MACROS_SVH
`define POLYLINE_RIBBON_TESSELLATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/prt_pkg.sv
// Types, constants and helper functions of the polyline ribbon tessellator.
`default_nettype none
package prt_pkg;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HOLD, OP_DIFF, OP_XMUL, OP_XACC, OP_ABS, OP_MAX,
    OP_NSHIFT, OP_ZOFF, OP_SQMUL, OP_SQACC, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_SCMUL, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_CORNER, OP_AVG,
    OP_EMIT, OP_COMMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_DIFF, S_XMUL, S_XACC, S_ABS, S_MAX, S_ZCHK, S_NORM,
    S_SQMUL, S_SQACC, S_SQRTI, S_SQRT, S_SCMUL, S_DIVI, S_DIV, S_DIVE,
    S_CORNER, S_AVG, S_EMITA, S_EMITB, S_COMMIT
  } state_t;

  typedef enum logic [1:0] {SEEN_NONE, SEEN_ONE, SEEN_QUAD} seen_t;

  typedef enum logic [1:0] {CN_SM, CN_SP, CN_EP, CN_EM} corner_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    logic [2:0] step;
    logic       quad_b;
    logic       last_v;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic norm_ok;
    logic out_free;
    logic in_last;
  } sts_t;

  localparam logic [31:0] WIDTH_RESET = 32'h0001_0000;
  localparam logic [5:0]  XTERM_LAST  = 6'd5;
  localparam logic [5:0]  SQRT_LAST   = 6'd30;
  localparam logic [5:0]  DIV_LAST    = 6'd32;
  localparam logic [5:0]  VTX_LAST    = 6'd5;
  localparam logic [1:0]  COMP_LAST   = 2'd2;
  localparam logic [62:0] SQRT_BIT0   = 63'h1000_0000_0000_0000;

  // Cross product terms, in order: d1*n2, d2*n1, d2*n0, d0*n2, d0*n1, d1*n0
  function automatic logic [1:0] xterm_d(input logic [2:0] t);
    logic [1:0] r;
    unique case (t)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] xterm_n(input logic [2:0] t);
    logic [1:0] r;
    unique case (t)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Quad order: start-, start+, end+, end+, end-, start-
  function automatic corner_t vtx_corner(input logic [2:0] v);
    corner_t r;
    unique case (v)
      3'd1:    r = CN_SP;
      3'd2:    r = CN_EP;
      3'd3:    r = CN_EP;
      3'd4:    r = CN_EM;
      default: r = CN_SM;
    endcase
    return r;
  endfunction

  function automatic logic vtx_u(input logic [2:0] v);
    return (v == 3'd2) || (v == 3'd3) || (v == 3'd4);
  endfunction

  function automatic logic vtx_v(input logic [2:0] v);
    return (v == 3'd1) || (v == 3'd2) || (v == 3'd3);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) r = v[31:0];
    else if (v[34]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/prt_dp.sv
// Datapath of the ribbon tessellator: operand registers, shared multiplier, sqrt and divider.
`default_nettype none
module prt_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic signed [31:0] in_normal_x,
  input  wire logic signed [31:0] in_normal_y,
  input  wire logic signed [31:0] in_normal_z,
  input  wire logic               in_last_point,
  input  wire prt_pkg::cmd_t      cmd,
  output prt_pkg::sts_t           sts,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [31:0]      out_vertex_x,
  output logic signed [31:0]      out_vertex_y,
  output logic signed [31:0]      out_vertex_z,
  output logic                    out_tex_u,
  output logic                    out_tex_v,
  output logic                    out_last_vertex
);

  logic [31:0]        width_r;
  logic signed [31:0] inp_r [3];
  logic signed [31:0] inn_r [3];
  logic signed [31:0] hp_r  [3];
  logic signed [31:0] hn_r  [3];
  logic               last_r;
  logic signed [31:0] d_r   [3];
  logic signed [65:0] prod_r;
  logic signed [64:0] c_r   [3];
  logic [63:0]        mag_r [3];
  logic [63:0]        m_r;
  logic [61:0]        sum_r;
  logic [62:0]        srem_r, sres_r, sbit_r;
  logic [32:0]        drem_r, dnum_r, dq_r;
  logic signed [33:0] off_r [3];
  logic signed [31:0] nsm_r [3], nsp_r [3], nem_r [3], nep_r [3];
  logic signed [31:0] qsm_r [3], qsp_r [3], qem_r [3], qep_r [3];
  logic               out_valid_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic               u_r, v_r, lv_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [62:0]        s_trial;
  logic [30:0]        len;
  logic [31:0]        dvsr;
  logic [32:0]        d_trial;
  logic [62:0]        numer;
  logic signed [33:0] qv;
  logic signed [34:0] hp35, np35, off35;
  logic signed [32:0] avg_m, avg_p;
  logic signed [31:0] sel_c [3];
  logic [1:0]         xd, xn;
  logic signed [32:0] diff [3];
  logic [63:0]        mx01;

  assign xd = prt_pkg::xterm_d(cmd.step);
  assign xn = prt_pkg::xterm_n(cmd.step);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      prt_pkg::OP_XMUL: begin
        mul_a = {d_r[xd][31], d_r[xd]};
        mul_b = {hn_r[xn][31], hn_r[xn]};
      end
      prt_pkg::OP_SQMUL: begin
        mul_a = {3'b000, mag_r[cmd.idx][29:0]};
        mul_b = {3'b000, mag_r[cmd.idx][29:0]};
      end
      prt_pkg::OP_SCMUL: begin
        mul_a = {3'b000, mag_r[cmd.idx][29:0]};
        mul_b = {1'b0, width_r};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {inp_r[k][31], inp_r[k]} - {hp_r[k][31], hp_r[k]};
    end
  end

  assign mx01    = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign s_trial = sres_r + sbit_r;
  assign len     = sres_r[30:0];
  assign dvsr    = {len, 1'b0};
  assign d_trial = {drem_r[31:0], dnum_r[32]};
  assign numer   = prod_r[62:0] + {32'd0, len};
  assign qv      = {1'b0, dq_r};

  assign hp35  = {{3{hp_r[cmd.idx][31]}}, hp_r[cmd.idx]};
  assign np35  = {{3{inp_r[cmd.idx][31]}}, inp_r[cmd.idx]};
  assign off35 = {off_r[cmd.idx][33], off_r[cmd.idx]};
  assign avg_m = {nsm_r[cmd.idx][31], nsm_r[cmd.idx]} + {qem_r[cmd.idx][31], qem_r[cmd.idx]};
  assign avg_p = {nsp_r[cmd.idx][31], nsp_r[cmd.idx]} + {qep_r[cmd.idx][31], qep_r[cmd.idx]};

  // Quad A closes the previous segment, quad B is the flush of the last one
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (prt_pkg::vtx_corner(cmd.step))
        prt_pkg::CN_SP: sel_c[k] = cmd.quad_b ? nsp_r[k] : qsp_r[k];
        prt_pkg::CN_EP: sel_c[k] = cmd.quad_b ? nep_r[k] : nsp_r[k];
        prt_pkg::CN_EM: sel_c[k] = cmd.quad_b ? nem_r[k] : nsm_r[k];
        default:        sel_c[k] = cmd.quad_b ? nsm_r[k] : qsm_r[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= prt_pkg::WIDTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) width_r <= cfg_wr_data;
      if (cmd.op == prt_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (cmd.op)
      prt_pkg::OP_LOAD: begin
        inp_r[0] <= in_point_x;
        inp_r[1] <= in_point_y;
        inp_r[2] <= in_point_z;
        inn_r[0] <= in_normal_x;
        inn_r[1] <= in_normal_y;
        inn_r[2] <= in_normal_z;
        last_r   <= in_last_point;
      end
      prt_pkg::OP_HOLD: begin
        for (int k = 0; k < 3; k++) begin
          hp_r[k] <= inp_r[k];
          hn_r[k] <= inn_r[k];
        end
      end
      prt_pkg::OP_DIFF: begin
        for (int k = 0; k < 3; k++) d_r[k] <= diff[k][32:1];
      end
      prt_pkg::OP_XACC: begin
        c_r[cmd.step[2:1]] <= cmd.step[0] ? (c_r[cmd.step[2:1]] - prod_r[64:0])
                                          : prod_r[64:0];
      end
      prt_pkg::OP_ABS: begin
        for (int k = 0; k < 3; k++) mag_r[k] <= c_r[k][64] ? 64'(-c_r[k]) : c_r[k][63:0];
      end
      prt_pkg::OP_MAX: m_r <= (mx01 > mag_r[2]) ? mx01 : mag_r[2];
      prt_pkg::OP_NSHIFT: begin
        if (m_r[63:30] != '0) begin
          m_r <= m_r >> 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end else begin
          m_r <= m_r << 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
        end
      end
      prt_pkg::OP_ZOFF: begin
        for (int k = 0; k < 3; k++) off_r[k] <= '0;
      end
      prt_pkg::OP_SQACC: sum_r <= ((cmd.idx == 2'd0) ? 62'd0 : sum_r) + prod_r[61:0];
      prt_pkg::OP_SQRT_INIT: begin
        srem_r <= {1'b0, sum_r};
        sres_r <= '0;
        sbit_r <= prt_pkg::SQRT_BIT0;
      end
      prt_pkg::OP_SQRT_STEP: begin
        if (srem_r >= s_trial) begin
          srem_r <= srem_r - s_trial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      prt_pkg::OP_DIV_INIT: begin
        drem_r <= {3'b000, numer[62:33]};
        dnum_r <= numer[32:0];
        dq_r   <= '0;
      end
      prt_pkg::OP_DIV_STEP: begin
        if (d_trial >= {1'b0, dvsr}) begin
          drem_r <= d_trial - {1'b0, dvsr};
          dq_r   <= {dq_r[31:0], 1'b1};
        end else begin
          drem_r <= d_trial;
          dq_r   <= {dq_r[31:0], 1'b0};
        end
        dnum_r <= {dnum_r[31:0], 1'b0};
      end
      prt_pkg::OP_DIV_END: off_r[cmd.idx] <= c_r[cmd.idx][64] ? -qv : qv;
      prt_pkg::OP_CORNER: begin
        nsm_r[cmd.idx] <= prt_pkg::sat32(hp35 - off35);
        nsp_r[cmd.idx] <= prt_pkg::sat32(hp35 + off35);
        nem_r[cmd.idx] <= prt_pkg::sat32(np35 - off35);
        nep_r[cmd.idx] <= prt_pkg::sat32(np35 + off35);
      end
      prt_pkg::OP_AVG: begin
        nsm_r[cmd.idx] <= avg_m[32:1];
        nsp_r[cmd.idx] <= avg_p[32:1];
      end
      prt_pkg::OP_EMIT: begin
        vx_r <= sel_c[0];
        vy_r <= sel_c[1];
        vz_r <= sel_c[2];
        u_r  <= prt_pkg::vtx_u(cmd.step);
        v_r  <= prt_pkg::vtx_v(cmd.step);
        lv_r <= cmd.last_v;
      end
      prt_pkg::OP_COMMIT: begin
        for (int k = 0; k < 3; k++) begin
          qsm_r[k] <= nsm_r[k];
          qsp_r[k] <= nsp_r[k];
          qem_r[k] <= nem_r[k];
          qep_r[k] <= nep_r[k];
          hp_r[k]  <= inp_r[k];
          hn_r[k]  <= inn_r[k];
        end
      end
      default: ;
    endcase
  end

  assign sts.m_zero   = (m_r == '0);
  assign sts.norm_ok  = (m_r[63:30] == '0) && m_r[29];
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.in_last  = last_r;

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = vx_r;
  assign out_vertex_y    = vy_r;
  assign out_vertex_z    = vz_r;
  assign out_tex_u       = u_r;
  assign out_tex_v       = v_r;
  assign out_last_vertex = lv_r;

endmodule
`default_nettype wire

### sv/prt_ctrl.sv
// Sequencer of the ribbon tessellator: walks the datapath through one point.
`default_nettype none
module prt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire prt_pkg::sts_t sts,
  output prt_pkg::cmd_t      cmd
);

  prt_pkg::state_t state_r, state_nxt;
  prt_pkg::seen_t  seen_r, seen_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [5:0]      step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prt_pkg::S_IDLE;
      seen_r  <= prt_pkg::SEEN_NONE;
      k_r     <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    unique case (state_r)
      prt_pkg::S_IDLE: if (in_valid) state_nxt = prt_pkg::S_DECIDE;
      prt_pkg::S_DECIDE: begin
        if (seen_r == prt_pkg::SEEN_NONE) begin
          seen_nxt  = sts.in_last ? prt_pkg::SEEN_NONE : prt_pkg::SEEN_ONE;
          state_nxt = prt_pkg::S_IDLE;
        end else begin
          state_nxt = prt_pkg::S_DIFF;
        end
      end
      prt_pkg::S_DIFF: begin
        step_nxt  = '0;
        state_nxt = prt_pkg::S_XMUL;
      end
      prt_pkg::S_XMUL: state_nxt = prt_pkg::S_XACC;
      prt_pkg::S_XACC: begin
        if (step_r == prt_pkg::XTERM_LAST) begin
          state_nxt = prt_pkg::S_ABS;
        end else begin
          step_nxt  = step_r + 6'd1;
          state_nxt = prt_pkg::S_XMUL;
        end
      end
      prt_pkg::S_ABS: state_nxt = prt_pkg::S_MAX;
      prt_pkg::S_MAX: state_nxt = prt_pkg::S_ZCHK;
      prt_pkg::S_ZCHK: begin
        k_nxt     = '0;
        state_nxt = sts.m_zero ? prt_pkg::S_CORNER : prt_pkg::S_NORM;
      end
      prt_pkg::S_NORM: if (sts.norm_ok) state_nxt = prt_pkg::S_SQMUL;
      prt_pkg::S_SQMUL: state_nxt = prt_pkg::S_SQACC;
      prt_pkg::S_SQACC: begin
        if (k_r == prt_pkg::COMP_LAST) begin
          state_nxt = prt_pkg::S_SQRTI;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = prt_pkg::S_SQMUL;
        end
      end
      prt_pkg::S_SQRTI: begin
        step_nxt  = '0;
        state_nxt = prt_pkg::S_SQRT;
      end
      prt_pkg::S_SQRT: begin
        if (step_r == prt_pkg::SQRT_LAST) begin
          k_nxt     = '0;
          state_nxt = prt_pkg::S_SCMUL;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      prt_pkg::S_SCMUL: state_nxt = prt_pkg::S_DIVI;
      prt_pkg::S_DIVI: begin
        step_nxt  = '0;
        state_nxt = prt_pkg::S_DIV;
      end
      prt_pkg::S_DIV: begin
        if (step_r == prt_pkg::DIV_LAST) state_nxt = prt_pkg::S_DIVE;
        else step_nxt = step_r + 6'd1;
      end
      prt_pkg::S_DIVE: begin
        if (k_r == prt_pkg::COMP_LAST) begin
          k_nxt     = '0;
          state_nxt = prt_pkg::S_CORNER;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = prt_pkg::S_SCMUL;
        end
      end
      prt_pkg::S_CORNER: begin
        if (k_r == prt_pkg::COMP_LAST) begin
          k_nxt    = '0;
          step_nxt = '0;
          if (seen_r == prt_pkg::SEEN_QUAD) state_nxt = prt_pkg::S_AVG;
          else if (sts.in_last) state_nxt = prt_pkg::S_EMITB;
          else state_nxt = prt_pkg::S_COMMIT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      prt_pkg::S_AVG: begin
        if (k_r == prt_pkg::COMP_LAST) begin
          step_nxt  = '0;
          state_nxt = prt_pkg::S_EMITA;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      prt_pkg::S_EMITA: begin
        if (sts.out_free) begin
          if (step_r == prt_pkg::VTX_LAST) begin
            step_nxt  = '0;
            state_nxt = sts.in_last ? prt_pkg::S_EMITB : prt_pkg::S_COMMIT;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      prt_pkg::S_EMITB: begin
        if (sts.out_free) begin
          if (step_r == prt_pkg::VTX_LAST) state_nxt = prt_pkg::S_COMMIT;
          else step_nxt = step_r + 6'd1;
        end
      end
      prt_pkg::S_COMMIT: begin
        seen_nxt  = sts.in_last ? prt_pkg::SEEN_NONE : prt_pkg::SEEN_QUAD;
        state_nxt = prt_pkg::S_IDLE;
      end
      default: state_nxt = prt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = prt_pkg::OP_NONE;
    cmd.idx    = k_r;
    cmd.step   = step_r[2:0];
    in_stall   = (state_r != prt_pkg::S_IDLE);
    unique case (state_r)
      prt_pkg::S_IDLE:   if (in_valid) cmd.op = prt_pkg::OP_LOAD;
      prt_pkg::S_DECIDE: if (seen_r == prt_pkg::SEEN_NONE) cmd.op = prt_pkg::OP_HOLD;
      prt_pkg::S_DIFF:   cmd.op = prt_pkg::OP_DIFF;
      prt_pkg::S_XMUL:   cmd.op = prt_pkg::OP_XMUL;
      prt_pkg::S_XACC:   cmd.op = prt_pkg::OP_XACC;
      prt_pkg::S_ABS:    cmd.op = prt_pkg::OP_ABS;
      prt_pkg::S_MAX:    cmd.op = prt_pkg::OP_MAX;
      prt_pkg::S_ZCHK:   if (sts.m_zero) cmd.op = prt_pkg::OP_ZOFF;
      prt_pkg::S_NORM:   if (!sts.norm_ok) cmd.op = prt_pkg::OP_NSHIFT;
      prt_pkg::S_SQMUL:  cmd.op = prt_pkg::OP_SQMUL;
      prt_pkg::S_SQACC:  cmd.op = prt_pkg::OP_SQACC;
      prt_pkg::S_SQRTI:  cmd.op = prt_pkg::OP_SQRT_INIT;
      prt_pkg::S_SQRT:   cmd.op = prt_pkg::OP_SQRT_STEP;
      prt_pkg::S_SCMUL:  cmd.op = prt_pkg::OP_SCMUL;
      prt_pkg::S_DIVI:   cmd.op = prt_pkg::OP_DIV_INIT;
      prt_pkg::S_DIV:    cmd.op = prt_pkg::OP_DIV_STEP;
      prt_pkg::S_DIVE:   cmd.op = prt_pkg::OP_DIV_END;
      prt_pkg::S_CORNER: cmd.op = prt_pkg::OP_CORNER;
      prt_pkg::S_AVG:    cmd.op = prt_pkg::OP_AVG;
      prt_pkg::S_EMITA: begin
        if (sts.out_free) cmd.op = prt_pkg::OP_EMIT;
        cmd.last_v = (step_r == prt_pkg::VTX_LAST) && !sts.in_last;
      end
      prt_pkg::S_EMITB: begin
        if (sts.out_free) cmd.op = prt_pkg::OP_EMIT;
        cmd.quad_b = 1'b1;
        cmd.last_v = (step_r == prt_pkg::VTX_LAST);
      end
      prt_pkg::S_COMMIT: cmd.op = prt_pkg::OP_COMMIT;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/polyline_ribbon_tessellator.sv
// Top level of the polyline ribbon tessellator.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | point, segment normal, last_point
//   out_    | output    | out_valid/out_stall | vertex xyz, tex u/v, last_vertex
//   cfg_    | input     | cfg_wr_en         | ribbon_width (Q16.16)
//
// One point at a time. A first point is only loaded and held; a later one
// runs the cross product on one shared multiplier, then, unless the side
// vector is zero, a normalising shift, a 31-step square root and three
// divisions, then none, 6 or 12 vertex transfers.
// Output stalls hold the sequencer in its emit states.
// Reset (synchronous, rst_n low) clears the sequencer and sets width to 1.0.
`default_nettype none
module polyline_ribbon_tessellator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic signed [31:0] in_normal_x,
  input  wire logic signed [31:0] in_normal_y,
  input  wire logic signed [31:0] in_normal_z,
  input  wire logic               in_last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_vertex_x,
  output logic signed [31:0]      out_vertex_y,
  output logic signed [31:0]      out_vertex_z,
  output logic                    out_tex_u,
  output logic                    out_tex_v,
  output logic                    out_last_vertex
);

  prt_pkg::cmd_t cmd;
  prt_pkg::sts_t sts;

  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_last_point   (in_last_point),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_vertex_z    (out_vertex_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_last_vertex (out_last_vertex)
  );

endmodule
`default_nettype wire

### sv/prt_checker.sv
// Port-level checks of the ribbon tessellator, bound to the top level.
`default_nettype none
`include "polyline_ribbon_tessellator_macros.svh"
module prt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_tex_u,
  input wire logic out_tex_v,
  input wire logic out_last_vertex
);

  // input transfer starts a busy period
  `PRT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "not busy after input transfer")
  // the flagged last vertex of a point's output is start- at texture (0,0)
  `PRT_ASSERT_SAME(a_last_tex, out_valid && out_last_vertex, !out_tex_u && !out_tex_v, "bad tex on last vertex")
  `PRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind polyline_ribbon_tessellator prt_checker u_prt_checker (.*);
`default_nettype wire
